FILE: rtl/esd_pkg.sv
// Escape decoder package: mode and status codes, digit constants, character helpers.
`timescale 1ns / 1ps
package esd_pkg;

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_HEX2 = 5'b00010,
        M_HEX4 = 5'b00100,
        M_HEX8 = 5'b01000,
        M_OCT  = 5'b10000
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNEXP_END  = 3'd1,
        ST_BAD_LETTER = 3'd2,
        ST_BAD_HEX    = 3'd3,
        ST_BAD_CP     = 3'd4,
        ST_SHORT_HEX  = 3'd5
    } t_status;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned ACC_W   = 32;
    localparam int unsigned OCT_ACC_W = 11;

    localparam logic [CNT_W-1:0] HEX2_DIGITS = 4'd2;
    localparam logic [CNT_W-1:0] HEX4_DIGITS = 4'd4;
    localparam logic [CNT_W-1:0] HEX8_DIGITS = 4'd8;
    localparam logic [CNT_W-1:0] OCT_DIGITS  = 4'd3;
    localparam logic [OCT_ACC_W-1:0] OCT_MAX = 11'h0FF;

    localparam logic [ACC_W-1:0] CP_MAX    = 32'h0010_FFFF;
    localparam logic [ACC_W-1:0] SURR_LO   = 32'h0000_D800;
    localparam logic [ACC_W-1:0] SURR_HI   = 32'h0000_DFFF;

    // Value of a one-letter escape, zero when the byte is not one.
    function automatic logic [BYTE_W-1:0] simple_esc(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = '0;
        unique case (c)
            "a":  v = 8'd7;
            "b":  v = 8'd8;
            "f":  v = 8'd12;
            "n":  v = 8'd10;
            "r":  v = 8'd13;
            "t":  v = 8'd9;
            "v":  v = 8'd11;
            "\\": v = 8'd92;
            "\"": v = 8'd34;
            "'":  v = 8'd39;
            "?":  v = 8'd63;
            default: v = '0;
        endcase
        return v;
    endfunction

    // {valid, nibble} of a hex digit.
    function automatic logic [4:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic is_oct(input logic [BYTE_W-1:0] c);
        return (c >= "0") && (c <= "7");
    endfunction

endpackage

FILE: rtl/esd_in_if.sv
// Input channel of the escape decoder: one body byte per beat.
`timescale 1ns / 1ps
interface esd_in_if
    import esd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              begins;
    logic              is_final;

    modport source (output valid, output text_byte, output begins, output is_final,
                    input ready);
    modport sink   (input valid, input text_byte, input begins, input is_final,
                    output ready);
endinterface

FILE: rtl/esd_out_if.sv
// Output channel of the escape decoder: one decoded escape per beat.
`timescale 1ns / 1ps
interface esd_out_if
    import esd_pkg::*;
();
    logic             valid;
    logic             ready;
    t_status          status;
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] consumed_count;

    modport source (output valid, output status, output code_point, output consumed_count,
                    input ready);
    modport sink   (input valid, input status, input code_point, input consumed_count,
                    output ready);
endinterface

FILE: rtl/escape_sequence_decoder_unit.sv
// Escape sequence decoder: decodes C string escape bodies byte by byte.
// Throughput: one input beat per cycle while the skid is empty; decode state updates at the accepting edge.
// A result is registered into the result register, or into the skid while that one still waits.
// A two-entry output buffer (result register plus skid) keeps input ready while one waits.
// Reset (synchronous, active low): decoder idle, counters cleared, output empty.
`timescale 1ns / 1ps
module escape_sequence_decoder_unit
    import esd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    esd_in_if.sink    i_in,
    esd_out_if.source o_out
);

    t_mode             r_mode,   n_mode;
    logic [CNT_W-1:0]  r_digits, n_digits;
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic              r_bad,    n_bad;
    logic [CNT_W-1:0]  r_bad_idx, n_bad_idx;

    logic              r_out_valid, r_skid_valid;
    t_status           r_out_status, r_skid_status;
    logic [CP_W-1:0]   r_out_cp,     r_skid_cp;
    logic [CNT_W-1:0]  r_out_cnt,    r_skid_cnt;

    logic              in_fire, out_fire;
    logic              res_valid;
    t_status           res_status;
    logic [CP_W-1:0]   res_cp;
    logic [CNT_W-1:0]  res_cnt;

    logic [BYTE_W-1:0]    c;
    logic [BYTE_W-1:0]    esc_v;
    logic [4:0]           hv;
    logic [CNT_W-1:0]     need;
    logic [OCT_ACC_W-1:0] oct_nv;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = r_out_valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;

    assign c      = i_in.text_byte;
    assign esc_v  = simple_esc(c);
    assign hv     = hex_val(c);
    assign oct_nv = {r_acc[BYTE_W-1:0], c[2:0]};

    always_comb begin
        unique case (r_mode)
            M_HEX2:  need = HEX2_DIGITS;
            M_HEX4:  need = HEX4_DIGITS;
            default: need = HEX8_DIGITS;
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_digits   = r_digits;
        n_acc      = r_acc;
        n_bad      = r_bad;
        n_bad_idx  = r_bad_idx;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_cp     = '0;
        res_cnt    = '0;
        if (in_fire) begin
            if (i_in.begins) begin
                priority if (esc_v != '0) begin
                    res_valid = 1'b1;
                    res_cp    = CP_W'(esc_v);
                    res_cnt   = CNT_W'(1);
                    n_mode    = M_IDLE;
                end else if (c == "x" || c == "u" || c == "U") begin
                    if (i_in.is_final) begin
                        res_valid  = 1'b1;
                        res_status = ST_SHORT_HEX;
                        n_mode     = M_IDLE;
                    end else begin
                        n_mode    = (c == "x") ? M_HEX2 : ((c == "u") ? M_HEX4 : M_HEX8);
                        n_digits  = '0;
                        n_acc     = '0;
                        n_bad     = 1'b0;
                        n_bad_idx = '0;
                    end
                end else if (is_oct(c)) begin
                    n_mode   = M_OCT;
                    n_digits = CNT_W'(1);
                    n_acc    = ACC_W'(c[2:0]);
                    if (i_in.is_final) begin
                        res_valid = 1'b1;
                        res_cp    = CP_W'(c[2:0]);
                        res_cnt   = CNT_W'(1);
                        n_mode    = M_IDLE;
                    end
                end else begin
                    res_valid  = 1'b1;
                    res_status = ST_BAD_LETTER;
                    n_mode     = M_IDLE;
                end
            end else begin
                unique case (r_mode)
                    M_HEX2, M_HEX4, M_HEX8: begin
                        if (!hv[4] && !r_bad) begin
                            n_bad     = 1'b1;
                            n_bad_idx = r_digits;
                        end
                        n_acc    = {r_acc[ACC_W-5:0], (hv[4] ? hv[3:0] : 4'd0)};
                        n_digits = r_digits + CNT_W'(1);
                        if (n_digits >= need) begin
                            res_valid = 1'b1;
                            n_mode    = M_IDLE;
                            priority if (n_bad) begin
                                res_status = ST_BAD_HEX;
                                res_cnt    = n_bad_idx;
                            end else if (r_mode != M_HEX2 && (n_acc > CP_MAX ||
                                         (n_acc >= SURR_LO && n_acc <= SURR_HI))) begin
                                res_status = ST_BAD_CP;
                                res_cnt    = need + CNT_W'(1);
                            end else begin
                                res_cp  = n_acc[CP_W-1:0];
                                res_cnt = need + CNT_W'(1);
                            end
                        end else if (i_in.is_final) begin
                            res_valid  = 1'b1;
                            res_status = ST_SHORT_HEX;
                            n_mode     = M_IDLE;
                        end
                    end
                    M_OCT: begin
                        if (is_oct(c) && oct_nv <= OCT_MAX) begin
                            n_acc    = ACC_W'(oct_nv);
                            n_digits = r_digits + CNT_W'(1);
                            if (n_digits >= OCT_DIGITS || i_in.is_final) begin
                                res_valid = 1'b1;
                                res_cp    = CP_W'(oct_nv);
                                res_cnt   = n_digits;
                                n_mode    = M_IDLE;
                            end
                        end else begin
                            // stop byte: not consumed
                            res_valid = 1'b1;
                            res_cp    = r_acc[CP_W-1:0];
                            res_cnt   = r_digits;
                            n_mode    = M_IDLE;
                        end
                    end
                    default: n_mode = M_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_digits  <= '0;
            r_acc     <= '0;
            r_bad     <= 1'b0;
            r_bad_idx <= '0;
        end else begin
            r_mode    <= n_mode;
            r_digits  <= n_digits;
            r_acc     <= n_acc;
            r_bad     <= n_bad;
            r_bad_idx <= n_bad_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_status <= r_skid_status;
                r_out_cp     <= r_skid_cp;
                r_out_cnt    <= r_skid_cnt;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_status <= res_status;
                r_out_cp     <= res_cp;
                r_out_cnt    <= res_cnt;
            end else begin
                r_skid_status <= res_status;
                r_skid_cp     <= res_cp;
                r_skid_cnt    <= res_cnt;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.code_point     = r_out_cp;
    assign o_out.consumed_count = r_out_cnt;

endmodule

FILE: sim/escape_sequence_decoder_unit_test.sv
// Testbench for escape_sequence_decoder_unit: random beats against a software decoder.
`timescale 1ns / 1ps
module escape_sequence_decoder_unit_test;
    import esd_pkg::*;

    localparam int unsigned RANDOM_BEATS = 800;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef logic [BYTE_W-1:0] t_text_q[$];

    typedef struct packed {
        t_status          status;
        logic [CP_W-1:0]  code_point;
        logic [CNT_W-1:0] consumed;
    } t_escape_result;

    logic i_clk;
    logic i_rst_n;
    bit   steady = 1'b0;
    logic [6:0] phase_cnt = '0;

    esd_in_if  in_if();
    esd_out_if out_if();

    escape_sequence_decoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        return -1;
    endfunction

    class escape_decode_scoreboard;
        t_mode            mode;
        logic [CNT_W-1:0] digits;
        logic [ACC_W-1:0] acc;
        bit               bad_seen;
        logic [CNT_W-1:0] bad_at;
        t_escape_result   expected_escapes[$];
        int unsigned      mismatches;

        function new();
            mode       = M_IDLE;
            digits     = '0;
            acc        = '0;
            bad_seen   = 1'b0;
            bad_at     = '0;
            mismatches = 0;
        endfunction

        function void finish_escape(t_status st, logic [CP_W-1:0] cp, logic [CNT_W-1:0] cnt);
            t_escape_result r;
            r.status     = st;
            r.code_point = cp;
            r.consumed   = cnt;
            expected_escapes.push_back(r);
            mode = M_IDLE;
        endfunction

        function void note_beat(logic [BYTE_W-1:0] c, logic first, logic last);
            int                   nib;
            logic [CNT_W-1:0]     need;
            logic [OCT_ACC_W-1:0] grown;
            if (first) begin
                case (c)
                    "a":  finish_escape(ST_OK, 7, 1);
                    "b":  finish_escape(ST_OK, 8, 1);
                    "f":  finish_escape(ST_OK, 12, 1);
                    "n":  finish_escape(ST_OK, 10, 1);
                    "r":  finish_escape(ST_OK, 13, 1);
                    "t":  finish_escape(ST_OK, 9, 1);
                    "v":  finish_escape(ST_OK, 11, 1);
                    "\\": finish_escape(ST_OK, 92, 1);
                    "\"": finish_escape(ST_OK, 34, 1);
                    "'":  finish_escape(ST_OK, 39, 1);
                    "?":  finish_escape(ST_OK, 63, 1);
                    "x", "u", "U": begin
                        if (last) begin
                            finish_escape(ST_SHORT_HEX, '0, '0);
                        end else begin
                            mode = (c == "x") ? M_HEX2 : ((c == "u") ? M_HEX4 : M_HEX8);
                            digits   = '0;
                            acc      = '0;
                            bad_seen = 1'b0;
                            bad_at   = '0;
                        end
                    end
                    default: begin
                        if (c >= "0" && c <= "7") begin
                            mode   = M_OCT;
                            digits = 1;
                            acc    = ACC_W'(c - 8'h30);
                            if (last) finish_escape(ST_OK, acc[CP_W-1:0], digits);
                        end else begin
                            finish_escape(ST_BAD_LETTER, '0, '0);
                        end
                    end
                endcase
            end else if (mode == M_HEX2 || mode == M_HEX4 || mode == M_HEX8) begin
                need = (mode == M_HEX2) ? HEX2_DIGITS :
                       ((mode == M_HEX4) ? HEX4_DIGITS : HEX8_DIGITS);
                nib = hex_nibble(c);
                if (nib < 0) begin
                    if (!bad_seen) begin
                        bad_seen = 1'b1;
                        bad_at   = digits;
                    end
                    nib = 0;
                end
                acc    = {acc[ACC_W-5:0], 4'(nib)};
                digits = digits + 1'b1;
                if (digits >= need) begin
                    if (bad_seen) begin
                        finish_escape(ST_BAD_HEX, '0, bad_at);
                    end else if (mode != M_HEX2 &&
                                 (acc > CP_MAX || (acc >= SURR_LO && acc <= SURR_HI))) begin
                        finish_escape(ST_BAD_CP, '0, need + 1'b1);
                    end else begin
                        finish_escape(ST_OK, acc[CP_W-1:0], need + 1'b1);
                    end
                end else if (last) begin
                    finish_escape(ST_SHORT_HEX, '0, '0);
                end
            end else if (mode == M_OCT) begin
                grown = {acc[7:0], 3'(c - 8'h30)};
                if (c >= "0" && c <= "7" && grown <= OCT_MAX) begin
                    acc    = ACC_W'(grown);
                    digits = digits + 1'b1;
                    if (digits >= OCT_DIGITS || last)
                        finish_escape(ST_OK, acc[CP_W-1:0], digits);
                end else begin
                    // stop byte: not consumed
                    finish_escape(ST_OK, acc[CP_W-1:0], digits);
                end
            end else begin
                mode = M_IDLE;
            end
        endfunction

        function void check_decoded(t_status st, logic [CP_W-1:0] cp, logic [CNT_W-1:0] cnt);
            t_escape_result want;
            if (expected_escapes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d code_point %h count %0d",
                             st, cp, cnt);
                return;
            end
            want = expected_escapes.pop_front();
            if (want.status !== st || want.code_point !== cp || want.consumed !== cnt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d code_point %h/%h count %0d/%0d (exp/got)",
                             want.status, st, want.code_point, cp, want.consumed, cnt);
            end
        endfunction
    endclass

    escape_decode_scoreboard sb = new();

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        phase_cnt <= phase_cnt + 1'b1;
        if (phase_cnt == '0) steady <= ($urandom_range(0, 3) == 0);
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_char();
        logic [BYTE_W-1:0] c;
        do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) >= 0);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] oct_char();
        return 8'h30 + 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [ACC_W-1:0] pick_code_point();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 32'hD7FF);
            1: return $urandom_range(32'hD800, 32'hDFFF);
            2: return $urandom_range(32'hE000, 32'h10FFFF);
            3: begin
                case ($urandom_range(0, 7))
                    0: return 32'h0;
                    1: return 32'hD7FF;
                    2: return 32'hD800;
                    3: return 32'hDFFF;
                    4: return 32'hE000;
                    5: return 32'h10FFFF;
                    6: return 32'h110000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // valid stays high across back-to-back beats; dropped only for a gap
    task automatic send_beat(input logic [BYTE_W-1:0] b, input logic first, input logic last);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.text_byte <= b;
        in_if.begins    <= first;
        in_if.is_final  <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_text(input string s, input bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], i == 0, fin_last && (i == s.len() - 1));
    endtask

    task automatic send_body(input t_text_q body, input bit fin_last);
        for (int i = 0; i < body.size(); i++)
            send_beat(body[i], i == 0, fin_last && (i == body.size() - 1));
    endtask

    task automatic run_directed();
        send_text("a", 1'b1);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_text("x", 1'b1);
        send_text("xFf", 1'b0);
        send_text("xg", 1'b1);
        send_text("xg1", 1'b0);
        send_text("7", 1'b1);
        send_text("377", 1'b0);
        send_text("400", 1'b0);
        send_beat(8'h00, 1'b0, 1'b0);
        send_text("u", 1'b0);
        send_text("uD800", 1'b0);
    endtask

    task automatic run_random();
        int unsigned counted;
        int unsigned kind;
        int unsigned n;
        int unsigned cut;
        int unsigned keep;
        logic [ACC_W-1:0] v;
        t_text_q body;
        bit fin_last;
        string simples;
        counted = 0;
        simples = "abfnrtv\\\"'?";
        while (counted < RANDOM_BEATS) begin
            body.delete();
            fin_last = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                body.push_back(simples[$urandom_range(0, simples.len() - 1)]);
            end else if (kind < 45) begin
                case ($urandom_range(0, 2))
                    0: begin
                        body.push_back("x");
                        n = 2;
                    end
                    1: begin
                        body.push_back("u");
                        n = 4;
                    end
                    default: begin
                        body.push_back("U");
                        n = 8;
                    end
                endcase
                v = pick_code_point();
                for (int i = n - 1; i >= 0; i--) body.push_back(hex_char(v[4*i +: 4]));
                if ($urandom_range(0, 99) < 15) body[$urandom_range(1, n)] = non_hex_char();
                if ($urandom_range(0, 99) < 5) body[$urandom_range(1, n)] = non_hex_char();
                cut = $urandom_range(0, 99);
                if (cut < 17) begin
                    keep = $urandom_range(1, n);
                    while (body.size() > keep) void'(body.pop_back());
                    fin_last = (cut < 12);
                end
            end else if (kind < 70) begin
                body.push_back(oct_char());
                repeat ($urandom_range(0, 3))
                    body.push_back(($urandom_range(0, 4) != 0) ? oct_char()
                                                                : 8'($urandom_range(0, 255)));
            end else if (kind < 78) begin
                body.push_back(8'($urandom_range(0, 255)));
            end
            if (kind < 78) begin
                counted += body.size();
                send_body(body, fin_last);
            end else if (kind < 89) begin
                repeat ($urandom_range(1, 3)) begin
                    send_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                    counted++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    counted++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_beat(in_if.text_byte, in_if.begins, in_if.is_final);
            if (out_if.valid && out_if.ready)
                sb.check_decoded(out_if.status, out_if.code_point, out_if.consumed_count);
        end
    end

    initial begin
        int unsigned n;
        out_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            out_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            n = idle_len();
            if (n != 0) begin
                out_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("escape_sequence_decoder_unit test failed");
        $finish;
    end

    initial begin
        in_if.valid     = 1'b0;
        in_if.text_byte = '0;
        in_if.begins    = 1'b0;
        in_if.is_final  = 1'b0;
        i_rst_n         = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_escapes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_escapes.size() == 0)
            $display("escape_sequence_decoder_unit test passed");
        else
            $display("escape_sequence_decoder_unit test failed");
        $finish;
    end

endmodule
